@@ hdl/stdq_pkg.sv @@
`timescale 1ns / 1ps

package stdq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EXPIRY_W    = 64;
  localparam int unsigned TAG_W       = 8;
  localparam int unsigned PENDING_W   = 5;

  localparam logic [EXPIRY_W-1:0] NO_TIMER_VALUE = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_FIRE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_CMP,
    S_ADD_LAST,
    S_FIRE_TAG,
    S_FIRE_HEAD,
    S_DONE
  } state_e;

  typedef struct packed {
    cmd_e                command;
    logic [EXPIRY_W-1:0] expiry_time;
    logic [TAG_W-1:0]    timer_tag;
  } in_item_t;

  typedef struct packed {
    logic [EXPIRY_W-1:0]  compare_value;
    logic                 fired_valid;
    logic [TAG_W-1:0]     fired_tag;
    status_e              status;
    logic [PENDING_W-1:0] pending_count;
  } out_item_t;

  typedef struct packed {
    logic [EXPIRY_W-1:0] expiry;
    logic [TAG_W-1:0]    tag;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Ring pointer step with wrap at any depth
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    if (p == IDX_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + IDX_W'(1);
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    if (p == '0) begin
      r = IDX_W'(QUEUE_DEPTH - 1);
    end else begin
      r = p - IDX_W'(1);
    end
    return r;
  endfunction

endpackage

@@ hdl/stdq_ram.sv @@
`timescale 1ns / 1ps

module stdq_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/stdq_ctrl.sv @@
`timescale 1ns / 1ps

module stdq_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  stdq_pkg::in_item_t          in_item_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output stdq_pkg::out_item_t         res_o,
  output logic                        ram_we_o,
  output logic [stdq_pkg::IDX_W-1:0]  ram_waddr_o,
  output stdq_pkg::entry_t            ram_wdata_o,
  output logic                        ram_re_o,
  output logic [stdq_pkg::IDX_W-1:0]  ram_raddr_o,
  input  stdq_pkg::entry_t            ram_rdata_i
);

  stdq_pkg::state_e state_q, state_d;

  logic [stdq_pkg::IDX_W-1:0]    head_q, head_d;
  logic [stdq_pkg::IDX_W-1:0]    tail_q, tail_d;
  logic [stdq_pkg::IDX_W-1:0]    pos_q, pos_d;
  logic [stdq_pkg::CNT_W-1:0]    count_q, count_d;
  logic [stdq_pkg::CNT_W-1:0]    left_q, left_d;
  logic [stdq_pkg::EXPIRY_W-1:0] when_q, when_d;
  logic [stdq_pkg::TAG_W-1:0]    tag_q, tag_d;
  logic [stdq_pkg::EXPIRY_W-1:0] head_exp_q, head_exp_d;
  logic                          fired_valid_q, fired_valid_d;
  logic [stdq_pkg::TAG_W-1:0]    fired_tag_q, fired_tag_d;
  stdq_pkg::status_e             status_q, status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stdq_pkg::S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q         <= pos_d;
    left_q        <= left_d;
    when_q        <= when_d;
    tag_q         <= tag_d;
    head_exp_q    <= head_exp_d;
    fired_valid_q <= fired_valid_d;
    fired_tag_q   <= fired_tag_d;
    status_q      <= status_d;
  end

  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    tail_d        = tail_q;
    pos_d         = pos_q;
    count_d       = count_q;
    left_d        = left_q;
    when_d        = when_q;
    tag_d         = tag_q;
    head_exp_d    = head_exp_q;
    fired_valid_d = fired_valid_q;
    fired_tag_d   = fired_tag_q;
    status_d      = status_q;
    in_ready_o    = 1'b0;
    res_valid_o   = 1'b0;
    ram_we_o      = 1'b0;
    ram_waddr_o   = pos_q;
    ram_wdata_o   = '{expiry: when_q, tag: tag_q};
    ram_re_o      = 1'b0;
    ram_raddr_o   = head_q;

    case (state_q)
      stdq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          when_d        = in_item_i.expiry_time;
          tag_d         = in_item_i.timer_tag;
          fired_valid_d = 1'b0;
          fired_tag_d   = '0;
          status_d      = stdq_pkg::ST_OK;
          pos_d         = tail_q;
          left_d        = count_q;
          if (in_item_i.command == stdq_pkg::CMD_ADD) begin
            if (count_q == stdq_pkg::CNT_W'(stdq_pkg::QUEUE_DEPTH)) begin
              status_d = stdq_pkg::ST_FULL;
              state_d  = stdq_pkg::S_DONE;
            end else if (count_q == '0) begin
              state_d = stdq_pkg::S_ADD_LAST;
            end else begin
              // fetch the last pending entry
              ram_re_o    = 1'b1;
              ram_raddr_o = stdq_pkg::idx_dec(tail_q);
              state_d     = stdq_pkg::S_ADD_CMP;
            end
          end else begin
            if (count_q == '0) begin
              status_d = stdq_pkg::ST_EMPTY;
              state_d  = stdq_pkg::S_DONE;
            end else begin
              ram_re_o    = 1'b1;
              ram_raddr_o = head_q;
              state_d     = stdq_pkg::S_FIRE_TAG;
            end
          end
        end
      end

      stdq_pkg::S_ADD_CMP: begin
        if (ram_rdata_i.expiry > when_q) begin
          // move the later entry up one slot, prefetch the one below it
          ram_we_o    = 1'b1;
          ram_waddr_o = pos_q;
          ram_wdata_o = ram_rdata_i;
          pos_d       = stdq_pkg::idx_dec(pos_q);
          left_d      = left_q - stdq_pkg::CNT_W'(1);
          if (left_q > stdq_pkg::CNT_W'(1)) begin
            ram_re_o    = 1'b1;
            ram_raddr_o = stdq_pkg::idx_dec(stdq_pkg::idx_dec(pos_q));
          end else begin
            state_d = stdq_pkg::S_ADD_LAST;
          end
        end else begin
          // slot found behind an entry with expiry <= new one
          ram_we_o    = 1'b1;
          ram_waddr_o = pos_q;
          count_d     = count_q + stdq_pkg::CNT_W'(1);
          tail_d      = stdq_pkg::idx_inc(tail_q);
          state_d     = stdq_pkg::S_DONE;
        end
      end

      stdq_pkg::S_ADD_LAST: begin
        // new timer lands at the head slot
        ram_we_o    = 1'b1;
        ram_waddr_o = pos_q;
        head_exp_d  = when_q;
        count_d     = count_q + stdq_pkg::CNT_W'(1);
        tail_d      = stdq_pkg::idx_inc(tail_q);
        state_d     = stdq_pkg::S_DONE;
      end

      stdq_pkg::S_FIRE_TAG: begin
        fired_valid_d = 1'b1;
        fired_tag_d   = ram_rdata_i.tag;
        head_d        = stdq_pkg::idx_inc(head_q);
        count_d       = count_q - stdq_pkg::CNT_W'(1);
        if (count_q > stdq_pkg::CNT_W'(1)) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = stdq_pkg::idx_inc(head_q);
          state_d     = stdq_pkg::S_FIRE_HEAD;
        end else begin
          state_d = stdq_pkg::S_DONE;
        end
      end

      stdq_pkg::S_FIRE_HEAD: begin
        head_exp_d = ram_rdata_i.expiry;
        state_d    = stdq_pkg::S_DONE;
      end

      stdq_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = stdq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = stdq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.compare_value = (count_q == '0) ? stdq_pkg::NO_TIMER_VALUE : head_exp_q;
    res_o.fired_valid   = fired_valid_q;
    res_o.fired_tag     = fired_tag_q;
    res_o.status        = status_q;
    res_o.pending_count = stdq_pkg::PENDING_W'(count_q);
  end

endmodule

@@ hdl/sorted_timer_deadline_queue.sv @@
`timescale 1ns / 1ps

// Sorted timer queue. Pending timers sit in a 16-entry ring memory, kept in
// expiry order from the head; the head's expiry is also held in a register
// so that every result carries the compare value to program (all ones when
// nothing is pending). Each item gives exactly one result. An add walks the
// ring backward from the tail through the single-port-read memory, moving
// each later entry up one slot per cycle until it meets an entry whose
// expiry is less than or equal to the new one, so equal expiries leave in
// the order they were added. A fire reads the head entry for the fired
// tag and, when entries remain, reads the new head's expiry from the
// memory in the cycle after the fired tag. Adds to a full table and fires
// on an empty one go straight to the result with the matching status. One
// item is worked on at a time; the result waits in an output register, so
// the next item is taken as soon as the result has left the sequencer.

module sorted_timer_deadline_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  stdq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output stdq_pkg::out_item_t out_item_o
);

  logic                       res_valid;
  logic                       res_ready;
  stdq_pkg::out_item_t        res;

  logic                       ram_we;
  logic [stdq_pkg::IDX_W-1:0] ram_waddr;
  stdq_pkg::entry_t           ram_wdata;
  logic                       ram_re;
  logic [stdq_pkg::IDX_W-1:0] ram_raddr;
  logic [stdq_pkg::ENTRY_W-1:0] ram_rdata;

  logic                       out_valid_q, out_valid_d;
  stdq_pkg::out_item_t        out_item_q, out_item_d;

  // Sequencer: insert walk, fire and head refresh
  stdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (stdq_pkg::entry_t'(ram_rdata))
  );

  // Timer ring: expiry and tag side by side in one entry
  stdq_ram #(
    .DATA_W (stdq_pkg::ENTRY_W),
    .DEPTH  (stdq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register: take a new result whenever the slot is free or draining
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (res_ready) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_item_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A full-table drop only happens with every slot in use
  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == stdq_pkg::ST_FULL)
      |-> (out_item_o.pending_count == stdq_pkg::PENDING_W'(stdq_pkg::QUEUE_DEPTH)))
    else $error("full status with free slots");

  // An empty table must program the idle compare value
  a_empty_compare : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.pending_count == '0)
      |-> (out_item_o.compare_value == stdq_pkg::NO_TIMER_VALUE))
    else $error("compare value not all ones on empty table");

  // A fired timer is never paired with an error status
  a_fire_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.fired_valid
      |-> (out_item_o.status == stdq_pkg::ST_OK))
    else $error("fired item with error status");

  // The sequencer holds off new items while one is in flight
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted while busy");

endmodule
